// ----- hw/rtl/fir_filter_stream_assert.svh -----
// assertion helpers, clocked on clock and disabled in reset
`ifndef FIR_FILTER_STREAM_ASSERT_SVH
`define FIR_FILTER_STREAM_ASSERT_SVH

// consequent in the same cycle
`define FIRS_ASSERT_HOLDS(name, ante, cons, text) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(text);

// consequent in the next cycle
`define FIRS_ASSERT_NEXT(name, ante, cons, text) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(text);

`endif

// ----- hw/rtl/firs_pkg.sv -----
package firs_pkg;

   localparam int CFG_W          = 6;
   localparam int INDEX_W        = 6;
   localparam int ACC_LIMIT_LOG2 = 61;

   typedef struct packed {
      logic emit;
      logic block_end;
   } firs_meta_type;

endpackage

// ----- hw/rtl/firs_tap.sv -----
module firs_tap #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 18
) (
   input  logic                                   clock,
   input  logic                                   shift_en,
   input  logic                                   clear,
   input  logic signed [SAMPLE_WIDTH-1:0]         tap_prev,
   output logic signed [SAMPLE_WIDTH-1:0]         tap_out,
   input  logic                                   coef_wr,
   input  logic signed [COEF_WIDTH-1:0]           coef_value,
   input  logic                                   active,
   input  logic                                   prod_en,
   output logic signed [SAMPLE_WIDTH+COEF_WIDTH-1:0] prod
);

   localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;

   logic signed [SAMPLE_WIDTH-1:0] tap_ff;
   logic signed [SAMPLE_WIDTH-1:0] tap_in;
   logic signed [COEF_WIDTH-1:0]   coef_ff;
   logic signed [COEF_WIDTH-1:0]   coef_in;
   logic signed [PROD_W-1:0]       prod_ff;
   logic signed [PROD_W-1:0]       prod_in;
   logic signed [PROD_W-1:0]       mult;

   assign mult = coef_ff * tap_ff;

   always_comb begin
      tap_in  = tap_ff;
      coef_in = coef_ff;
      prod_in = prod_ff;
      if (shift_en) begin
         tap_in = clear ? '0 : tap_prev;
      end
      if (coef_wr) begin
         coef_in = coef_value;
      end
      if (prod_en) begin
         prod_in = active ? mult : '0;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff  <= tap_in;
      coef_ff <= coef_in;
      prod_ff <= prod_in;
   end

   assign tap_out = tap_ff;
   assign prod    = prod_ff;

endmodule

// ----- hw/rtl/firs_sum_tree.sv -----
module firs_sum_tree import firs_pkg::*; #(
   parameter int N    = 64,
   parameter int IN_W = 34
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  firs_meta_type                     in_meta,
   input  logic [N-1:0][IN_W-1:0]            in_data,
   output logic                              out_valid,
   input  logic                              out_ready,
   output firs_meta_type                     out_meta,
   output logic signed [IN_W+$clog2(N)-1:0]  out_sum
);

   localparam int LEVELS = $clog2(N);
   localparam int LEAVES = 1 << LEVELS;
   localparam int SUM_W  = IN_W + LEVELS;

   logic signed [SUM_W-1:0] leaf [LEAVES];
   logic signed [SUM_W-1:0] sum_ff [1:LEAVES-1];
   logic signed [SUM_W-1:0] sum_in [1:LEAVES-1];
   logic [LEVELS-1:0]       vld_ff;
   logic [LEVELS-1:0]       vld_in;
   firs_meta_type           meta_ff [LEVELS];
   firs_meta_type           meta_in [LEVELS];
   logic [LEVELS:0]         rdy;

   assign rdy[LEVELS] = out_ready;

   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < N) begin : g_used
         assign leaf[i] = SUM_W'($signed(in_data[i]));
      end else begin : g_pad
         assign leaf[i] = '0;
      end
   end

   for (genvar s = 0; s < LEVELS; s++) begin : g_stage
      assign rdy[s] = !vld_ff[s] || rdy[s+1];
      if (s == 0) begin : g_first
         assign vld_in[s]  = rdy[s] ? in_valid : vld_ff[s];
         assign meta_in[s] = rdy[s] ? in_meta : meta_ff[s];
      end else begin : g_later
         assign vld_in[s]  = rdy[s] ? vld_ff[s-1] : vld_ff[s];
         assign meta_in[s] = rdy[s] ? meta_ff[s-1] : meta_ff[s];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_in[s];
         end
         meta_ff[s] <= meta_in[s];
      end
   end

   for (genvar i = 1; i < LEAVES; i++) begin : g_node
      localparam int STAGE = LEVELS - $clog2(i + 1);
      if (2 * i >= LEAVES) begin : g_bottom
         assign sum_in[i] = rdy[STAGE] ? leaf[2*i-LEAVES] + leaf[2*i+1-LEAVES] : sum_ff[i];
      end else begin : g_inner
         assign sum_in[i] = rdy[STAGE] ? sum_ff[2*i] + sum_ff[2*i+1] : sum_ff[i];
      end
      always_ff @(posedge clock) begin
         sum_ff[i] <= sum_in[i];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[LEVELS-1];
   assign out_meta  = meta_ff[LEVELS-1];
   assign out_sum   = sum_ff[1];

endmodule

// ----- hw/rtl/fir_filter_stream.sv -----
// Streaming direct-form FIR filter with a loadable coefficient table. Every request beat is
// either a coefficient write (tuser 0) or a sample (tuser 1), and one beat is taken per clock
// as long as the result side keeps up. Samples shift through a row of MAX_ORDER+1 tap cells,
// each holding one history sample, one coefficient and one registered multiplier; the products
// are summed in a registered adder tree of log2(MAX_ORDER+1) levels, then rounded and saturated.
// A result passes the tap, product, adder tree, rounding and output registers. A sample with
// tlast set is followed by filter_order zero beats; these go out one per clock while rsp_tready
// is high and stall the request side once the pipeline is full. Results appear only once
// filter_order+1 samples of a block have been pushed. The coefficient table has no reset and
// taps at or below filter_order must be written before they are used. The user must write
// filter_order on the csr channel only while the filter is idle; the block does not enforce
// this.
module fir_filter_stream import firs_pkg::*; #(
   parameter int MAX_ORDER    = 63,
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 18
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   req_tvalid,
   output logic                                                   req_tready,
   // coef_index, coef_value, sample_in, zero fill
   input  logic [((INDEX_W+COEF_WIDTH+SAMPLE_WIDTH+7)/8)*8-1:0]   req_tdata,
   // action
   input  logic                                                   req_tuser,
   input  logic                                                   req_tlast,
   output logic                                                   rsp_tvalid,
   input  logic                                                   rsp_tready,
   // sample_out, zero fill
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]                      rsp_tdata,
   output logic                                                   rsp_tlast,
   input  logic                                                   csr_valid,
   output logic                                                   csr_ready,
   input  logic [CFG_W-1:0]                                       csr_data
);

   `include "fir_filter_stream_assert.svh"

   localparam int TAPS    = MAX_ORDER + 1;
   localparam int ORDER_W = $clog2(TAPS);
   localparam int SEEN_W  = $clog2(TAPS + 1);
   localparam int PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int SUM_W   = PROD_W + $clog2(TAPS);
   localparam int CLAMP_W = (SUM_W > 63) ? SUM_W : 63;
   localparam int RND_W   = CLAMP_W + 1;
   localparam int FRAC    = COEF_WIDTH - 1;
   localparam int RSP_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;

   localparam logic ACTION_COEF   = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   localparam logic signed [CLAMP_W-1:0] ACC_MAX = CLAMP_W'(64'sd1 <<< ACC_LIMIT_LOG2);
   localparam logic signed [CLAMP_W-1:0] ACC_MIN = -ACC_MAX;
   localparam logic signed [RND_W-1:0]   ROUND_HALF = RND_W'(64'sd1 <<< (FRAC - 1));
   localparam logic signed [RND_W-1:0]   SAT_HI = RND_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [RND_W-1:0]   SAT_LO = -SAT_HI - 1;

   logic [INDEX_W-1:0]             coef_index;
   logic signed [COEF_WIDTH-1:0]   coef_value;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;
   logic                           sample_acc;
   logic                           coef_acc;

   logic [CFG_W-1:0]   filter_order_ff;
   logic [CFG_W-1:0]   filter_order_in;
   logic [ORDER_W-1:0] order_eff;

   logic               clear_ff;
   logic               clear_in;
   logic [SEEN_W-1:0]  seen_ff;
   logic [SEEN_W-1:0]  seen_in;
   logic [SEEN_W-1:0]  seen_base;
   logic [SEEN_W-1:0]  seen_next;
   logic               v0_ff;
   logic               v0_in;
   firs_meta_type      meta0_ff;
   firs_meta_type      meta0_in;

   logic               p_vld_ff;
   logic               p_vld_in;
   firs_meta_type      p_meta_ff;
   firs_meta_type      p_meta_in;
   logic               p_rdy;

   logic signed [SAMPLE_WIDTH-1:0] tap [TAPS];
   logic signed [SAMPLE_WIDTH-1:0] tap_prev [TAPS];
   logic [TAPS-1:0]                tap_clear;
   logic [TAPS-1:0]                tap_active;
   logic [TAPS-1:0]                coef_wr;
   logic [TAPS-1:0][PROD_W-1:0]    prod;

   logic                    tree_in_ready;
   logic                    tree_out_valid;
   firs_meta_type           tree_out_meta;
   logic signed [SUM_W-1:0] tree_sum;

   logic                      r_vld_ff;
   logic                      r_vld_in;
   firs_meta_type             r_meta_ff;
   firs_meta_type             r_meta_in;
   logic signed [RND_W-1:0]   r_val_ff;
   logic signed [RND_W-1:0]   r_val_in;
   logic signed [CLAMP_W-1:0] sum_ext;
   logic signed [CLAMP_W-1:0] clamped;
   logic                      r_rdy;
   logic                      r_take;

   logic signed [RND_W-1:0]        shifted;
   logic [SAMPLE_WIDTH-1:0]        sat_val;
   logic                           out_load;
   logic                           tail_busy;
   logic [ORDER_W-1:0]             tail_cnt_ff;
   logic [ORDER_W-1:0]             tail_cnt_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]        rsp_data_ff;
   logic [SAMPLE_WIDTH-1:0]        rsp_data_in;
   logic                           rsp_last_ff;
   logic                           rsp_last_in;

   // request fields
   assign coef_index = req_tdata[INDEX_W-1:0];
   assign coef_value = req_tdata[INDEX_W +: COEF_WIDTH];
   assign sample_in  = req_tdata[INDEX_W+COEF_WIDTH +: SAMPLE_WIDTH];

   assign req_tready = !v0_ff || p_rdy;
   assign sample_acc = req_tvalid && req_tready && (req_tuser == ACTION_SAMPLE);
   assign coef_acc   = req_tvalid && req_tready && (req_tuser == ACTION_COEF);

   // order register
   assign csr_ready       = 1'b1;
   assign filter_order_in = csr_valid ? csr_data : filter_order_ff;
   assign order_eff       = (filter_order_ff > CFG_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER)
                                                                 : filter_order_ff[ORDER_W-1:0];

   // sample count and history entry stage
   always_comb begin
      seen_base = clear_ff ? '0 : seen_ff;
      seen_next = (seen_base == SEEN_W'(TAPS)) ? seen_base : seen_base + SEEN_W'(1);
      seen_in   = seen_ff;
      clear_in  = clear_ff;
      v0_in     = p_rdy ? 1'b0 : v0_ff;
      meta0_in  = meta0_ff;
      if (sample_acc) begin
         seen_in            = seen_next;
         clear_in           = req_tlast;
         v0_in              = 1'b1;
         meta0_in.emit      = seen_next > SEEN_W'(order_eff);
         meta0_in.block_end = req_tlast;
      end
   end

   // tap row
   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         tap_active[k] = ORDER_W'(k) <= order_eff;
         coef_wr[k]    = coef_acc && (coef_index == INDEX_W'(k));
         if (k == 0) begin
            tap_prev[k]  = sample_in;
            tap_clear[k] = 1'b0;
         end else begin
            tap_prev[k]  = tap[k-1];
            tap_clear[k] = clear_ff;
         end
      end
   end

   for (genvar k = 0; k < TAPS; k++) begin : g_tap
      firs_tap #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH),
         .COEF_WIDTH   (COEF_WIDTH)
      ) u_tap (
         .clock      (clock),
         .shift_en   (sample_acc),
         .clear      (tap_clear[k]),
         .tap_prev   (tap_prev[k]),
         .tap_out    (tap[k]),
         .coef_wr    (coef_wr[k]),
         .coef_value (coef_value),
         .active     (tap_active[k]),
         .prod_en    (p_rdy),
         .prod       (prod[k])
      );
   end

   // product stage
   assign p_rdy     = !p_vld_ff || tree_in_ready;
   assign p_vld_in  = p_rdy ? v0_ff : p_vld_ff;
   assign p_meta_in = p_rdy ? meta0_ff : p_meta_ff;

   firs_sum_tree #(
      .N    (TAPS),
      .IN_W (PROD_W)
   ) u_sum_tree (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_vld_ff),
      .in_ready  (tree_in_ready),
      .in_meta   (p_meta_ff),
      .in_data   (prod),
      .out_valid (tree_out_valid),
      .out_ready (r_rdy),
      .out_meta  (tree_out_meta),
      .out_sum   (tree_sum)
   );

   // guard clamp and rounding offset
   always_comb begin
      sum_ext = CLAMP_W'(tree_sum);
      if (sum_ext > ACC_MAX) begin
         clamped = ACC_MAX;
      end else if (sum_ext < ACC_MIN) begin
         clamped = ACC_MIN;
      end else begin
         clamped = sum_ext;
      end
   end

   assign r_rdy     = !r_vld_ff || r_take;
   assign r_vld_in  = r_rdy ? tree_out_valid : r_vld_ff;
   assign r_meta_in = r_rdy ? tree_out_meta : r_meta_ff;
   assign r_val_in  = r_rdy ? RND_W'(clamped) + ROUND_HALF : r_val_ff;

   // shift, saturate and tail
   assign shifted   = r_val_ff >>> FRAC;
   assign out_load  = !rsp_valid_ff || rsp_tready;
   assign tail_busy = tail_cnt_ff != '0;
   assign r_take    = r_vld_ff && out_load && !tail_busy;

   always_comb begin
      if (shifted > SAT_HI) begin
         sat_val = SAT_HI[SAMPLE_WIDTH-1:0];
      end else if (shifted < SAT_LO) begin
         sat_val = SAT_LO[SAMPLE_WIDTH-1:0];
      end else begin
         sat_val = shifted[SAMPLE_WIDTH-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      tail_cnt_in  = tail_cnt_ff;
      if (out_load) begin
         if (tail_busy) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_last_in  = tail_cnt_ff == ORDER_W'(1);
            tail_cnt_in  = tail_cnt_ff - ORDER_W'(1);
         end else if (r_vld_ff) begin
            if (r_meta_ff.emit) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat_val;
               rsp_last_in  = !(r_meta_ff.block_end && (order_eff != '0));
            end
            if (r_meta_ff.block_end) begin
               tail_cnt_in = order_eff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_order_ff <= '0;
         clear_ff        <= 1'b1;
         seen_ff         <= '0;
         v0_ff           <= 1'b0;
         p_vld_ff        <= 1'b0;
         r_vld_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         tail_cnt_ff     <= '0;
      end else begin
         filter_order_ff <= filter_order_in;
         clear_ff        <= clear_in;
         seen_ff         <= seen_in;
         v0_ff           <= v0_in;
         p_vld_ff        <= p_vld_in;
         r_vld_ff        <= r_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
         tail_cnt_ff     <= tail_cnt_in;
      end
      meta0_ff    <= meta0_in;
      p_meta_ff   <= p_meta_in;
      r_meta_ff   <= r_meta_in;
      r_val_ff    <= r_val_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

   `FIRS_ASSERT_HOLDS(a_tail_bound, tail_busy, tail_cnt_ff <= order_eff, "tail count beyond order")
   `FIRS_ASSERT_NEXT(a_tail_zero, out_load && tail_busy, rsp_tvalid && (rsp_data_ff == '0), "tail beat not zero")
   `FIRS_ASSERT_NEXT(a_tail_last, out_load && (tail_cnt_ff == ORDER_W'(1)), rsp_tlast, "tail end not last")
   `FIRS_ASSERT_NEXT(a_tree_hold, tree_out_valid && !r_rdy, tree_out_valid, "stalled sum dropped")

endmodule
